// ===== rtl/core/dhri_pkg.sv =====
// ---------------------------------------------------------------------------
// dhri_pkg
// Codes and constants shared by the decoder host register interface.
// ---------------------------------------------------------------------------
package dhri_pkg;

    // request codes
    localparam logic [3:0] REQ_MC1_WR   = 4'd0;
    localparam logic [3:0] REQ_MC23_WR  = 4'd1;
    localparam logic [3:0] REQ_SETUP_WR = 4'd2;
    localparam logic [3:0] REQ_CMD_WR   = 4'd3;
    localparam logic [3:0] REQ_DATA_WR  = 4'd4;
    localparam logic [3:0] REQ_STAT0_RD = 4'd5;
    localparam logic [3:0] REQ_STAT1_RD = 4'd6;
    localparam logic [3:0] REQ_STAT2_RD = 4'd7;
    localparam logic [3:0] REQ_USER_RD  = 4'd8;

    // operating states
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_NORMAL = 2'd2;

    // command outcome
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_ACCEPTED = 2'd1;
    localparam logic [1:0] CMD_WRONG_ST = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

    // command bytes
    localparam logic [7:0] CMD_GO        = 8'h00;
    localparam logic [7:0] CMD_END_FIRST = 8'h81;
    localparam logic [7:0] CMD_END_LAST  = 8'h84;

    // bus mode
    localparam logic [7:0] BUS_MODE_RESET = 8'h10;
    localparam int         MODE_WIDE_BIT  = 7;
    localparam int         MODE_LSB_BIT   = 6;

    // status values
    localparam logic [7:0] STAT0_BASE = 8'h20;
    localparam logic [7:0] STAT1_VAL  = 8'h0c;
    localparam logic [7:0] STAT2_VAL  = 8'h01;
    localparam logic [7:0] USER_VAL   = 8'h00;

endpackage

// ===== rtl/core/decoder_host_register_interface.sv =====
// ---------------------------------------------------------------------------
// decoder_host_register_interface
// Host bus access decoder: byte-stream writes to microcode, setup, command
// and data ports, and status reads (constant but for status 0, which carries the operating state).
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  access  | in        | i_in_valid / o_in_stall | i_req_type, i_high_lane, i_write_data
//  result  | out       | o_out_valid / i_out_stall | o_read_data, o_drq, o_cmd_result
//
//  one access per cycle sustained unless the result stalls; input register, then
//  result register, with both bytes of a 16-bit access resolved in one pass
//  register state advances as an access moves into the result register
//  a stalled result holds the input register; the access side stalls only
//  when both registers are full
//  synchronous active-low reset; no clearing pass, setup entry 0 is a register
//  of its own since no other setup entry is ever read back
// ---------------------------------------------------------------------------
module decoder_host_register_interface #(
    parameter int SETUP_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_req_type,
    input  logic        i_high_lane,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data,
    output logic        o_drq,
    output logic [1:0]  o_cmd_result
);

    localparam int             PTR_W   = $clog2(SETUP_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(SETUP_DEPTH);

    typedef struct packed {
        logic [1:0]       op_state;
        logic [7:0]       bus_mode;
        logic [7:0]       setup0;
        logic [PTR_W-1:0] setup_ptr;
        logic [15:0]      mc1_cnt;
        logic [15:0]      mc23_cnt;
        logic             cmd_second;
        logic             req_line;
    } t_regs;

    typedef struct packed {
        t_regs      regs;
        logic [1:0] res;
    } t_step;

    // one byte into one port
    function automatic t_step f_byte(t_regs s, logic [3:0] port, logic [7:0] b);
        t_step r;
        r.regs = s;
        r.res  = dhri_pkg::CMD_NONE;
        case (port)
            dhri_pkg::REQ_MC1_WR: begin
                r.regs.mc23_cnt  = '0;
                r.regs.setup_ptr = '0;
                r.regs.mc1_cnt   = s.mc1_cnt + 16'd1;
            end
            dhri_pkg::REQ_MC23_WR: begin
                r.regs.mc1_cnt   = '0;
                r.regs.setup_ptr = '0;
                r.regs.mc23_cnt  = s.mc23_cnt + 16'd1;
            end
            dhri_pkg::REQ_SETUP_WR: begin
                r.regs.mc1_cnt  = '0;
                r.regs.mc23_cnt = '0;
                if (s.setup_ptr < PTR_END) begin
                    if (s.setup_ptr == '0) begin
                        r.regs.setup0 = b;
                    end
                    r.regs.setup_ptr = s.setup_ptr + PTR_W'(1);
                end
            end
            dhri_pkg::REQ_CMD_WR: begin
                r.regs.cmd_second = !s.cmd_second;
                if (s.cmd_second) begin
                    if (b == dhri_pkg::CMD_GO) begin
                        if (s.op_state == dhri_pkg::ST_IDLE) begin
                            r.regs.bus_mode = s.setup0;
                            r.regs.op_state = dhri_pkg::ST_NORMAL;
                            r.regs.req_line = 1'b1;
                            r.res           = dhri_pkg::CMD_ACCEPTED;
                        end else begin
                            r.res = dhri_pkg::CMD_WRONG_ST;
                        end
                    end else if (b >= dhri_pkg::CMD_END_FIRST &&
                                 b <= dhri_pkg::CMD_END_LAST) begin
                        if (s.op_state == dhri_pkg::ST_NORMAL) begin
                            r.regs.op_state = dhri_pkg::ST_IDLE;
                            r.regs.req_line = 1'b0;
                            r.res           = dhri_pkg::CMD_ACCEPTED;
                        end else begin
                            r.res = dhri_pkg::CMD_WRONG_ST;
                        end
                    end else begin
                        r.res = dhri_pkg::CMD_UNKNOWN;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // input register
    logic        r_in_valid;
    logic [3:0]  r_req_type;
    logic        r_high_lane;
    logic [15:0] r_write_data;

    // result register
    logic        r_out_valid;
    logic [15:0] r_read_data;
    logic        r_drq;
    logic [1:0]  r_cmd_result;

    t_regs       r_regs;
    t_regs       n_regs;
    logic [15:0] n_read_data;
    logic [1:0]  n_cmd_result;

    logic        advance;
    logic        in_accept;
    logic        lsb_first;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  rd_byte;
    t_step       step1;
    t_step       step2;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign lo_byte = r_write_data[7:0];
    assign hi_byte = r_write_data[15:8];

    // byte order fixed by the mode at the start of the access
    always_comb begin
        if (r_regs.bus_mode[dhri_pkg::MODE_WIDE_BIT]) begin
            lsb_first   = r_regs.bus_mode[dhri_pkg::MODE_LSB_BIT] ^ r_high_lane;
            first_byte  = lsb_first ? lo_byte : hi_byte;
            second_byte = lsb_first ? hi_byte : lo_byte;
        end else begin
            lsb_first   = 1'b0;
            first_byte  = r_high_lane ? hi_byte : lo_byte;
            second_byte = first_byte;
        end
    end

    assign step1 = f_byte(r_regs, r_req_type, first_byte);
    assign step2 = f_byte(step1.regs, r_req_type, second_byte);

    always_comb begin
        n_regs       = r_regs;
        n_cmd_result = dhri_pkg::CMD_NONE;
        if (r_req_type <= dhri_pkg::REQ_DATA_WR) begin
            if (r_regs.bus_mode[dhri_pkg::MODE_WIDE_BIT]) begin
                n_regs       = step2.regs;
                n_cmd_result = (step1.res != dhri_pkg::CMD_NONE) ? step1.res : step2.res;
            end else begin
                n_regs       = step1.regs;
                n_cmd_result = step1.res;
            end
        end
    end

    always_comb begin
        case (r_req_type)
            dhri_pkg::REQ_STAT0_RD: rd_byte = dhri_pkg::STAT0_BASE | {6'd0, r_regs.op_state};
            dhri_pkg::REQ_STAT1_RD: rd_byte = dhri_pkg::STAT1_VAL;
            dhri_pkg::REQ_STAT2_RD: rd_byte = dhri_pkg::STAT2_VAL;
            dhri_pkg::REQ_USER_RD:  rd_byte = dhri_pkg::USER_VAL;
            default:                rd_byte = 8'd0;
        endcase
        n_read_data = r_high_lane ? {rd_byte, 8'd0} : {8'd0, rd_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_regs.op_state    <= dhri_pkg::ST_IDLE;
            r_regs.bus_mode    <= dhri_pkg::BUS_MODE_RESET;
            r_regs.setup0      <= dhri_pkg::BUS_MODE_RESET;
            r_regs.setup_ptr   <= '0;
            r_regs.mc1_cnt     <= '0;
            r_regs.mc23_cnt    <= '0;
            r_regs.cmd_second  <= 1'b0;
            r_regs.req_line    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type   <= i_req_type;
            r_high_lane  <= i_high_lane;
            r_write_data <= i_write_data;
        end
        if (advance) begin
            r_read_data  <= n_read_data;
            r_drq        <= n_regs.req_line;
            r_cmd_result <= n_cmd_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_drq        = r_drq;
    assign o_cmd_result = r_cmd_result;

    a_drq_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.req_line == (r_regs.op_state == dhri_pkg::ST_NORMAL))
        else $error("request line out of step with operating state");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.setup_ptr <= PTR_END)
        else $error("setup pointer past end of setup file");

    a_cmd_only_on_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_req_type != dhri_pkg::REQ_CMD_WR |=> o_cmd_result == dhri_pkg::CMD_NONE)
        else $error("command result on a non-command access");

    a_held_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_req_type) && $stable(r_write_data))
        else $error("held access lost from input register");

    a_mc_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.mc1_cnt == 16'd0 || r_regs.mc23_cnt == 16'd0)
        else $error("both microcode counters running");

endmodule
